[rtl/core/fsip_pkg.sv]
// shared types and constants of the integer format printer
package fsip_pkg;

    localparam int ARG_BITS    = 32;
    localparam int MAX_WIDTH   = 32;
    localparam int PAD_W       = $clog2(MAX_WIDTH + 1);
    localparam int STACK_DEPTH = ARG_BITS;
    localparam int NDIG_W      = $clog2(STACK_DEPTH + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_SPEC_C  = 8'h63;
    localparam logic [7:0] CH_SPEC_D  = 8'h64;
    localparam logic [7:0] CH_SPEC_U  = 8'h75;
    localparam logic [7:0] CH_SPEC_B  = 8'h62;
    localparam logic [7:0] CH_SPEC_O  = 8'h6F;
    localparam logic [7:0] CH_SPEC_X  = 8'h78;
    localparam logic [7:0] CH_SPEC_UX = 8'h58;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_ERR  = 2'd1,
        CMD_END  = 2'd2,
        CMD_CONV = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        RDX_DEC = 2'd0,
        RDX_BIN = 2'd1,
        RDX_OCT = 2'd2,
        RDX_HEX = 2'd3
    } radix_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [7:0]            chr;
        logic [ARG_BITS-1:0]   value;
        radix_t                radix;
        logic                  upper;
        logic                  neg;
        logic [PAD_W-1:0]      pad;
    } cmd_t;

endpackage

[rtl/core/fsip_front.sv]
// front end: format byte decode, flag and width tracking, command issue
module fsip_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_fmt_char,
    input  logic [fsip_pkg::ARG_BITS-1:0] s_arg_value,
    input  logic                          q_full,
    output logic                          q_push,
    output fsip_pkg::cmd_t                q_cmd
);

    typedef enum logic [1:0] {
        PH_LITERAL = 2'b01,
        PH_PERCENT = 2'b10
    } phase_t;

    localparam logic [9:0] MAX_W10 = 10'(fsip_pkg::MAX_WIDTH);

    phase_t                     phase_reg, phase_next;
    logic [fsip_pkg::PAD_W-1:0] pad_reg, pad_next;
    logic                       zflag_reg, zflag_next;
    logic                       inwd_reg, inwd_next;

    logic                       accept;
    logic                       is_digit;
    logic [9:0]                 width_acc;
    logic [fsip_pkg::ARG_BITS-1:0] neg_value;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign is_digit  = (s_fmt_char >= fsip_pkg::CH_ZERO) && (s_fmt_char <= fsip_pkg::CH_NINE);
    assign width_acc = {1'b0, pad_reg, 3'b000} + {3'b000, pad_reg, 1'b0}
                     + {6'd0, s_fmt_char[3:0]};
    assign neg_value = ~s_arg_value + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        pad_next   = pad_reg;
        zflag_next = zflag_reg;
        inwd_next  = inwd_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.kind = fsip_pkg::CMD_CHAR;
        q_cmd.chr  = s_fmt_char;
        if (accept) begin
            if (s_fmt_char == fsip_pkg::CH_NUL) begin
                q_push     = 1'b1;
                q_cmd.kind = fsip_pkg::CMD_END;
                phase_next = PH_LITERAL;
                pad_next   = '0;
                zflag_next = 1'b0;
                inwd_next  = 1'b0;
            end else if (phase_reg == PH_LITERAL) begin
                if (s_fmt_char == fsip_pkg::CH_PERCENT) begin
                    phase_next = PH_PERCENT;
                end else begin
                    q_push = 1'b1;
                end
            end else if (is_digit && (inwd_reg || s_fmt_char != fsip_pkg::CH_ZERO)) begin
                pad_next  = (width_acc > MAX_W10) ? fsip_pkg::PAD_W'(fsip_pkg::MAX_WIDTH)
                                                  : width_acc[fsip_pkg::PAD_W-1:0];
                inwd_next = 1'b1;
            end else if (s_fmt_char == fsip_pkg::CH_ZERO) begin
                zflag_next = 1'b1;
            end else begin
                q_push     = 1'b1;
                phase_next = PH_LITERAL;
                pad_next   = '0;
                zflag_next = 1'b0;
                inwd_next  = 1'b0;
                q_cmd.value = s_arg_value;
                unique case (s_fmt_char)
                    fsip_pkg::CH_PERCENT: begin
                        q_cmd.kind = fsip_pkg::CMD_CHAR;
                    end
                    fsip_pkg::CH_SPEC_C: begin
                        q_cmd.kind = fsip_pkg::CMD_CHAR;
                        q_cmd.chr  = s_arg_value[7:0];
                    end
                    fsip_pkg::CH_SPEC_D: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_DEC;
                        q_cmd.neg   = s_arg_value[fsip_pkg::ARG_BITS-1];
                        q_cmd.value = s_arg_value[fsip_pkg::ARG_BITS-1] ? neg_value
                                                                        : s_arg_value;
                        q_cmd.pad   = zflag_reg ? pad_reg : '0;
                    end
                    fsip_pkg::CH_SPEC_U: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_DEC;
                    end
                    fsip_pkg::CH_SPEC_B: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_BIN;
                    end
                    fsip_pkg::CH_SPEC_O: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_OCT;
                    end
                    fsip_pkg::CH_SPEC_X: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_HEX;
                    end
                    fsip_pkg::CH_SPEC_UX: begin
                        q_cmd.kind  = fsip_pkg::CMD_CONV;
                        q_cmd.radix = fsip_pkg::RDX_HEX;
                        q_cmd.upper = 1'b1;
                    end
                    default: begin
                        q_cmd.kind = fsip_pkg::CMD_ERR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LITERAL;
            pad_reg   <= '0;
            zflag_reg <= 1'b0;
            inwd_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            zflag_reg <= zflag_next;
            inwd_reg  <= inwd_next;
        end
    end

endmodule

[rtl/core/fsip_cmd_fifo.sv]
// short command queue between front and back end
module fsip_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fsip_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output fsip_pkg::cmd_t pop_cmd,
    output logic           empty
);

    fsip_pkg::cmd_t                  mem_reg [fsip_pkg::FIFO_DEPTH];
    logic [fsip_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fsip_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fsip_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == fsip_pkg::FIFO_CNT_W'(fsip_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_fifo_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fsip_pkg::FIFO_CNT_W'(fsip_pkg::FIFO_DEPTH))
        else $error("command queue count out of range");

endmodule

[rtl/core/fsip_back.sv]
// back end: digit extraction, padding, character output and running count
module fsip_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  fsip_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_char,
    output logic           m_last,
    output logic           m_error,
    output logic [31:0]    m_total_printed
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIVMUL = 8'b0000_0010,
        S_DIVSUB = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_PREP   = 8'b0001_0000,
        S_SIGN   = 8'b0010_0000,
        S_PAD    = 8'b0100_0000,
        S_DIGIT  = 8'b1000_0000
    } state_t;

    localparam int          AB     = fsip_pkg::ARG_BITS;
    localparam int          Q_W    = AB - 3;
    localparam logic [31:0] RECIP  = 32'hCCCC_CCCD;

    state_t                     state_reg, state_next;
    logic [AB-1:0]              val_reg, val_next;
    fsip_pkg::radix_t           radix_reg, radix_next;
    logic                       upper_reg, upper_next;
    logic                       neg_reg, neg_next;
    logic [fsip_pkg::PAD_W-1:0] pad_reg, pad_next;
    logic [fsip_pkg::PAD_W-1:0] pad_left_reg, pad_left_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic [3:0]                 stack_reg [fsip_pkg::STACK_DEPTH];
    logic [3:0]                 stack_next [fsip_pkg::STACK_DEPTH];
    logic [fsip_pkg::NDIG_W-1:0] ndig_reg, ndig_next;
    logic [31:0]                total_reg, total_next;

    logic                       m_valid_reg;
    logic [7:0]                 m_out_char_reg;
    logic                       m_last_reg;
    logic                       m_error_reg;
    logic [31:0]                m_total_reg;

    logic                       out_free;
    logic                       emit, emit_last, emit_err, emit_count, emit_end;
    logic [7:0]                 emit_char;
    logic                       push_dig, pop_dig;
    logic [3:0]                 dig_in;
    logic [63:0]                product;
    logic [AB-1:0]              q_ext, q_times10, rem_full, shifted;
    logic [fsip_pkg::NDIG_W:0]  len;
    logic [31:0]                total_inc;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] base;
        begin
            base = up ? fsip_pkg::CH_UP_A : fsip_pkg::CH_LOW_A;
            if (d < 4'd10) begin
                digit_char = fsip_pkg::CH_ZERO + {4'd0, d};
            end else begin
                digit_char = base + {4'd0, d} - 8'd10;
            end
        end
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign product   = {{(64-AB){1'b0}}, val_reg} * {32'd0, RECIP};
    assign q_ext     = {3'b000, q_reg};
    assign q_times10 = (q_ext << 3) + (q_ext << 1);
    assign rem_full  = val_reg - q_times10;
    assign len       = {1'b0, ndig_reg} + {{fsip_pkg::NDIG_W{1'b0}}, neg_reg};
    assign total_inc = (total_reg == 32'hFFFF_FFFF) ? total_reg : total_reg + 32'd1;

    always_comb begin
        unique case (radix_reg)
            fsip_pkg::RDX_BIN: begin
                dig_in  = {3'b000, val_reg[0]};
                shifted = val_reg >> 1;
            end
            fsip_pkg::RDX_OCT: begin
                dig_in  = {1'b0, val_reg[2:0]};
                shifted = val_reg >> 3;
            end
            default: begin
                dig_in  = val_reg[3:0];
                shifted = val_reg >> 4;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        radix_next    = radix_reg;
        upper_next    = upper_reg;
        neg_next      = neg_reg;
        pad_next      = pad_reg;
        pad_left_next = pad_left_reg;
        q_next        = q_reg;
        ndig_next     = ndig_reg;
        q_pop         = 1'b0;
        push_dig      = 1'b0;
        pop_dig       = 1'b0;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_err      = 1'b0;
        emit_count    = 1'b0;
        emit_end      = 1'b0;
        emit_char     = q_cmd.chr;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    if (q_cmd.kind == fsip_pkg::CMD_CONV) begin
                        q_pop      = 1'b1;
                        val_next   = q_cmd.value;
                        radix_next = q_cmd.radix;
                        upper_next = q_cmd.upper;
                        neg_next   = q_cmd.neg;
                        pad_next   = q_cmd.pad;
                        ndig_next  = '0;
                        state_next = (q_cmd.radix == fsip_pkg::RDX_DEC) ? S_DIVMUL : S_SHIFT;
                    end else if (out_free) begin
                        q_pop     = 1'b1;
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        unique case (q_cmd.kind)
                            fsip_pkg::CMD_ERR: emit_err = 1'b1;
                            fsip_pkg::CMD_END: begin
                                emit_end  = 1'b1;
                                emit_char = fsip_pkg::CH_NUL;
                            end
                            default: emit_count = 1'b1;
                        endcase
                    end
                end
            end
            S_DIVMUL: begin
                q_next     = product[63:35];
                state_next = S_DIVSUB;
            end
            S_DIVSUB: begin
                push_dig   = 1'b1;
                ndig_next  = ndig_reg + 1'b1;
                val_next   = q_ext;
                state_next = (q_reg == '0) ? S_PREP : S_DIVMUL;
            end
            S_SHIFT: begin
                push_dig   = 1'b1;
                ndig_next  = ndig_reg + 1'b1;
                val_next   = shifted;
                state_next = (shifted == '0) ? S_PREP : S_SHIFT;
            end
            S_PREP: begin
                pad_left_next = ({1'b0, pad_reg} > len)
                              ? fsip_pkg::PAD_W'({1'b0, pad_reg} - len) : '0;
                state_next    = neg_reg ? S_SIGN : S_PAD;
            end
            S_SIGN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_count = 1'b1;
                    emit_char  = fsip_pkg::CH_MINUS;
                    state_next = S_PAD;
                end
            end
            S_PAD: begin
                if (pad_left_reg == '0) begin
                    state_next = S_DIGIT;
                end else if (out_free) begin
                    emit          = 1'b1;
                    emit_count    = 1'b1;
                    emit_char     = fsip_pkg::CH_ZERO;
                    pad_left_next = pad_left_reg - 1'b1;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_count = 1'b1;
                    emit_char  = digit_char(stack_reg[0], upper_reg);
                    emit_last  = (ndig_reg == fsip_pkg::NDIG_W'(1));
                    pop_dig    = 1'b1;
                    ndig_next  = ndig_reg - 1'b1;
                    if (ndig_reg == fsip_pkg::NDIG_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < fsip_pkg::STACK_DEPTH; i++) begin
            stack_next[i] = stack_reg[i];
        end
        if (push_dig) begin
            for (int i = 1; i < fsip_pkg::STACK_DEPTH; i++) begin
                stack_next[i] = stack_reg[i-1];
            end
            stack_next[0] = state_reg == S_DIVSUB ? rem_full[3:0] : dig_in;
        end else if (pop_dig) begin
            for (int i = 0; i < fsip_pkg::STACK_DEPTH - 1; i++) begin
                stack_next[i] = stack_reg[i+1];
            end
            stack_next[fsip_pkg::STACK_DEPTH-1] = '0;
        end
    end

    always_comb begin
        total_next = total_reg;
        if (emit && emit_count) begin
            total_next = total_inc;
        end else if (emit && emit_end) begin
            total_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        radix_reg    <= radix_next;
        upper_reg    <= upper_next;
        neg_reg      <= neg_next;
        pad_reg      <= pad_next;
        pad_left_reg <= pad_left_next;
        q_reg        <= q_next;
        stack_reg    <= stack_next;
        if (emit) begin
            m_out_char_reg <= emit_char;
            m_last_reg     <= emit_last;
            m_error_reg    <= emit_err;
            m_total_reg    <= emit_count ? total_inc : total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ndig_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ndig_reg  <= ndig_next;
            total_reg <= total_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_char      = m_out_char_reg;
    assign m_last          = m_last_reg;
    assign m_error         = m_error_reg;
    assign m_total_printed = m_total_reg;

    a_digit_stack_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIGIT) |-> (ndig_reg != '0))
        else $error("digit output with empty digit stack");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_error_reg) |-> m_last_reg)
        else $error("error word not marked last");

    a_partial_word_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg != S_IDLE))
        else $error("non-last word pending while back end idle");

endmodule

[rtl/core/format_string_integer_printer.sv]
// top level of the integer format printer: front end, command queue, back end
//
// Input words carry one format byte (s_fmt_char) and one 32-bit argument
// (s_arg_value) on a valid/ready channel. Output words carry one ASCII
// character each with last, error and the running character count.
// Plain bytes, %%, %c and errors give one word, %u %b %o %x %X give a run
// of digits, %d gives digits after an optional minus sign and zero padding,
// flag/width bytes and '%' give none, and a zero byte gives one word with
// the total and restarts the count. A single character word passes through
// the command queue and the output register when the back end is idle. A
// conversion, once taken from the queue, spends one shift step per digit for
// %b %o %x %X and a reciprocal multiply step then a remainder step per digit
// for %u %d, then takes a padding decision step, the sign and padding steps,
// and emits one character per cycle unless the receiver stalls.
// The front end keeps taking bytes while the back end works, up to four
// queued commands; s_ready drops when the queue is full.
// When the receiver stalls, the output word holds and the back end waits.
// Reset (aresetn low at a clock edge) empties the queue, drops any pending
// word and clears the count, width and flags.
module format_string_integer_printer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_fmt_char,
    input  logic [fsip_pkg::ARG_BITS-1:0] s_arg_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_char,
    output logic                          m_last,
    output logic                          m_error,
    output logic [31:0]                   m_total_printed
);

    fsip_pkg::cmd_t push_cmd;
    fsip_pkg::cmd_t pop_cmd;
    logic           q_push, q_full, q_pop, q_empty;

    fsip_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_fmt_char  (s_fmt_char),
        .s_arg_value (s_arg_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    fsip_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    fsip_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_last          (m_last),
        .m_error         (m_error),
        .m_total_printed (m_total_printed)
    );

endmodule

[tb/fsip_char_checker.sv]
// checker for the integer format printer: predicts output words and compares them
module fsip_char_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_fmt_char,
    input  logic [fsip_pkg::ARG_BITS-1:0] s_arg_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_out_char,
    input  logic                          m_last,
    input  logic                          m_error,
    input  logic [31:0]                   m_total_printed,
    output int                            fail_count,
    output int                            pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_LITERAL = 2'b01,
        PH_PERCENT = 2'b10
    } fmt_phase_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        err;
        logic [31:0] total;
    } char_word_t;

    char_word_t  expected_chars[$];
    char_word_t  step_chars[$];

    fmt_phase_t  phase = PH_LITERAL;
    logic [5:0]  pad_width = '0;
    logic        zero_pad = 1'b0;
    logic        in_width = 1'b0;
    logic [31:0] char_total = '0;
    int          reported = 0;

    initial begin
        fail_count = 0;
        pending_words = 0;
    end

    function automatic void push_word(input logic [7:0] ch, input logic err);
        char_word_t w;
        w.ch = ch;
        w.last = 1'b0;
        w.err = err;
        w.total = char_total;
        step_chars.push_back(w);
    endfunction

    function automatic void emit_char(input logic [7:0] ch);
        if (char_total != 32'hFFFF_FFFF) begin
            char_total = char_total + 32'd1;
        end
        push_word(ch, 1'b0);
    endfunction

    function automatic void clear_spec();
        phase = PH_LITERAL;
        pad_width = '0;
        zero_pad = 1'b0;
        in_width = 1'b0;
    endfunction

    function automatic void emit_digits(input logic [31:0] value, input logic [4:0] radix,
                                        input logic upper);
        logic [7:0]  digs[$];
        logic [31:0] v;
        logic [31:0] r;
        v = value;
        do begin
            r = v % radix;
            if (r < 10) begin
                digs.push_front(fsip_pkg::CH_ZERO + r[7:0]);
            end else begin
                digs.push_front((upper ? fsip_pkg::CH_UP_A : fsip_pkg::CH_LOW_A)
                                + r[7:0] - 8'd10);
            end
            v = v / radix;
        end while (v != 0);
        foreach (digs[i]) begin
            emit_char(digs[i]);
        end
    endfunction

    function automatic void emit_signed(input logic [31:0] a);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] v;
        int          len;
        neg = a[31];
        mag = neg ? (~a + 32'd1) : a;
        len = 1;
        v = mag;
        while (v >= 10) begin
            v = v / 10;
            len++;
        end
        if (neg) begin
            len++;
            emit_char(fsip_pkg::CH_MINUS);
        end
        if (zero_pad) begin
            for (int k = len; k < pad_width; k++) begin
                emit_char(fsip_pkg::CH_ZERO);
            end
        end
        emit_digits(mag, 5'd10, 1'b0);
    endfunction

    task automatic predict_format_byte(input logic [7:0] c, input logic [31:0] a);
        int w;
        step_chars.delete();
        if (c == fsip_pkg::CH_NUL) begin
            push_word(fsip_pkg::CH_NUL, 1'b0);
            clear_spec();
            char_total = '0;
        end else if (phase != PH_PERCENT) begin
            if (c == fsip_pkg::CH_PERCENT) begin
                phase = PH_PERCENT;
            end else begin
                emit_char(c);
            end
        end else if (c >= fsip_pkg::CH_ZERO && c <= fsip_pkg::CH_NINE &&
                     (in_width || c != fsip_pkg::CH_ZERO)) begin
            w = pad_width * 10 + (c - fsip_pkg::CH_ZERO);
            pad_width = (w > fsip_pkg::MAX_WIDTH) ? 6'(fsip_pkg::MAX_WIDTH) : 6'(w);
            in_width = 1'b1;
        end else if (c == fsip_pkg::CH_ZERO) begin
            zero_pad = 1'b1;
        end else begin
            unique case (c)
                fsip_pkg::CH_PERCENT: emit_char(fsip_pkg::CH_PERCENT);
                fsip_pkg::CH_SPEC_C:  emit_char(a[7:0]);
                fsip_pkg::CH_SPEC_D:  emit_signed(a);
                fsip_pkg::CH_SPEC_U:  emit_digits(a, 5'd10, 1'b0);
                fsip_pkg::CH_SPEC_B:  emit_digits(a, 5'd2, 1'b0);
                fsip_pkg::CH_SPEC_O:  emit_digits(a, 5'd8, 1'b0);
                fsip_pkg::CH_SPEC_X:  emit_digits(a, 5'd16, 1'b0);
                fsip_pkg::CH_SPEC_UX: emit_digits(a, 5'd16, 1'b1);
                default:              push_word(c, 1'b1);
            endcase
            clear_spec();
        end
        if (step_chars.size() > 0) begin
            step_chars[step_chars.size() - 1].last = 1'b1;
        end
        foreach (step_chars[i]) begin
            expected_chars.push_back(step_chars[i]);
        end
    endtask

    always @(posedge aclk) begin
        char_word_t exp_w;
        if (!aresetn) begin
            expected_chars.delete();
            clear_spec();
            char_total = '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_format_byte(s_fmt_char, s_arg_value);
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (reported < 10) begin
                        $display("unexpected word: char %02h last %0b error %0b total %0d",
                                 m_out_char, m_last, m_error, m_total_printed);
                    end
                    reported++;
                end else begin
                    exp_w = expected_chars.pop_front();
                    if (exp_w.ch !== m_out_char || exp_w.last !== m_last ||
                        exp_w.err !== m_error || exp_w.total !== m_total_printed) begin
                        fail_count <= fail_count + 1;
                        if (reported < 10) begin
                            $display("mismatch: expected char %02h last %0b error %0b total %0d",
                                     exp_w.ch, exp_w.last, exp_w.err, exp_w.total);
                            $display("          got      char %02h last %0b error %0b total %0d",
                                     m_out_char, m_last, m_error, m_total_printed);
                        end
                        reported++;
                    end
                end
            end
        end
        pending_words <= expected_chars.size();
    end

endmodule

[tb/tb_top.sv]
// top of the integer format printer testbench: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_LOW_S = 8'h73;
    localparam logic [7:0] CH_LIT_A = 8'h41;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_fmt_char = '0;
    logic [fsip_pkg::ARG_BITS-1:0] s_arg_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [7:0]                    m_out_char;
    logic                          m_last;
    logic                          m_error;
    logic [31:0]                   m_total_printed;
    int                            fail_count;
    int                            pending_words;

    int                            src_idle_pct = 0;
    int                            sink_stall_pct = 0;
    int                            hold_cycles = 0;
    int                            items_sent = 0;

    logic [7:0] conv_specs[8] = '{fsip_pkg::CH_PERCENT, fsip_pkg::CH_SPEC_C,
                                  fsip_pkg::CH_SPEC_D, fsip_pkg::CH_SPEC_U,
                                  fsip_pkg::CH_SPEC_B, fsip_pkg::CH_SPEC_O,
                                  fsip_pkg::CH_SPEC_X, fsip_pkg::CH_SPEC_UX};

    format_string_integer_printer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_fmt_char      (s_fmt_char),
        .s_arg_value     (s_arg_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_last          (m_last),
        .m_error         (m_error),
        .m_total_printed (m_total_printed)
    );

    fsip_char_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_fmt_char      (s_fmt_char),
        .s_arg_value     (s_arg_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_last          (m_last),
        .m_error         (m_error),
        .m_total_printed (m_total_printed),
        .fail_count      (fail_count),
        .pending_words   (pending_words)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // receiver: long hold-off first, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_word(input logic [7:0] c, input logic [31:0] a);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_fmt_char <= c;
        s_arg_value <= a;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(99);
            5:       return 32'h0 - $urandom_range(1, 99);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_literal();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == fsip_pkg::CH_PERCENT);
        return c;
    endfunction

    task automatic send_conversion();
        if ($urandom_range(1)) begin
            send_word(fsip_pkg::CH_ZERO, $urandom);
        end
        if ($urandom_range(2) != 0) begin
            send_word(fsip_pkg::CH_ZERO + 8'($urandom_range(1, 9)), $urandom);
            if ($urandom_range(4) == 0) begin
                send_word(fsip_pkg::CH_ZERO + 8'($urandom_range(0, 9)), $urandom);
            end
        end
        send_word(conv_specs[$urandom_range(7)], rand_arg());
    endtask

    // mostly well-formed format strings, with some noise and broken specs
    task automatic run_random(input int n_items);
        int target;
        int r;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 35) begin
                send_word(rand_literal(), $urandom);
            end else if (r < 80) begin
                send_word(fsip_pkg::CH_PERCENT, $urandom);
                send_conversion();
            end else if (r < 88) begin
                send_word(fsip_pkg::CH_PERCENT, $urandom);
                send_word(8'($urandom_range(1, 255)), $urandom);
            end else if (r < 95) begin
                send_word(8'($urandom_range(1, 255)), $urandom);
            end else begin
                send_word(fsip_pkg::CH_NUL, $urandom);
            end
        end
        send_word(fsip_pkg::CH_NUL, $urandom);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words
        send_word(CH_LIT_A, 32'h0);
        send_word(8'hFF, 32'hFFFF_FFFF);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_PERCENT, 32'h0);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_SPEC_C, 32'hFFFF_FFFF);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_ZERO, 32'h0);
        send_word(fsip_pkg::CH_ZERO + 8'd3, 32'h0);
        send_word(fsip_pkg::CH_NINE, 32'h0);
        send_word(fsip_pkg::CH_SPEC_D, 32'h8000_0000);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_SPEC_B, 32'hFFFF_FFFF);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_SPEC_UX, 32'hDEAD_BEEF);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(CH_LOW_S, 32'h0);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_MINUS, 32'h0);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_UP_A, 32'h0);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_ZERO + 8'd5, 32'h0);
        send_word(fsip_pkg::CH_NUL, 32'h0);
        send_word(fsip_pkg::CH_PERCENT, 32'h0);  send_word(fsip_pkg::CH_SPEC_O, 32'h0);
        send_word(fsip_pkg::CH_NUL, 32'hFFFF_FFFF);
        wait_drained();

        run_random(50);
        wait_drained();

        src_idle_pct = 50;
        run_random(50);
        wait_drained();

        src_idle_pct = 0;
        sink_stall_pct = 50;
        run_random(50);
        wait_drained();

        src_idle_pct = 30;
        sink_stall_pct = 30;
        run_random(50);
        wait_drained();

        // receiver holds off while the sender keeps the queue full
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 8; i++) begin
            send_word(fsip_pkg::CH_PERCENT, 32'h0);
            send_word(fsip_pkg::CH_SPEC_B, 32'hFFFF_FFFF);
        end
        send_word(fsip_pkg::CH_NUL, 32'h0);

        wait_drained();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
